/* src/rv32x_pkg.sv */
// Shared types and command codes for the rv32 subset execute step.
// No dependencies.
package rv32x_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int RIDX_W    = $clog2(REG_COUNT);
    localparam int CMD_W     = 5;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [CMD_W-1:0] CMD_LI   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_LW   = 5'd1;
    localparam logic [CMD_W-1:0] CMD_SW   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_ADD  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_AND  = 5'd4;
    localparam logic [CMD_W-1:0] CMD_DIV  = 5'd5;
    localparam logic [CMD_W-1:0] CMD_MUL  = 5'd6;
    localparam logic [CMD_W-1:0] CMD_REM  = 5'd7;
    localparam logic [CMD_W-1:0] CMD_OR   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_SLL  = 5'd9;
    localparam logic [CMD_W-1:0] CMD_SRL  = 5'd10;
    localparam logic [CMD_W-1:0] CMD_SUB  = 5'd11;
    localparam logic [CMD_W-1:0] CMD_XOR  = 5'd12;
    localparam logic [CMD_W-1:0] CMD_ADDI = 5'd13;
    localparam logic [CMD_W-1:0] CMD_ANDI = 5'd14;
    localparam logic [CMD_W-1:0] CMD_ORI  = 5'd15;
    localparam logic [CMD_W-1:0] CMD_SLLI = 5'd16;
    localparam logic [CMD_W-1:0] CMD_SRLI = 5'd17;
    localparam logic [CMD_W-1:0] CMD_XORI = 5'd18;
    localparam logic [CMD_W-1:0] CMD_BEQ  = 5'd19;
    localparam logic [CMD_W-1:0] CMD_BNE  = 5'd20;

    // classified word passed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [RIDX_W-1:0] rd;
        logic [RIDX_W-1:0] ra;
        logic [RIDX_W-1:0] rb;
        logic [XLEN-1:0]   imm;
        logic              use_imm;
        logic              is_div;
    } op_t;

endpackage

/* src/rv32x_front.sv */
// Front end: accepts decoded words, classifies them and queues them.
// Depends on rv32x_pkg.
module rv32x_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid,
    output logic                   stall,
    input  logic [4:0]             command,
    input  logic [4:0]             dest_reg,
    input  logic [4:0]             src_reg_a,
    input  logic [4:0]             src_reg_b,
    input  logic signed [31:0]     immediate,
    output logic                   q_valid,
    output rv32x_pkg::op_t         q_op,
    input  logic                   q_take
);
    import rv32x_pkg::*;

    op_t               mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    op_t               op_in;
    logic              push;
    logic              pop;

    always_comb
    begin
        op_in.cmd     = command;
        op_in.rd      = dest_reg;
        op_in.ra      = src_reg_a;
        op_in.rb      = src_reg_b;
        op_in.imm     = immediate;
        op_in.use_imm = (command >= CMD_ADDI) && (command <= CMD_XORI);
        op_in.is_div  = (command == CMD_DIV) || (command == CMD_REM);
    end

    assign stall   = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign push    = valid && !stall;
    assign q_valid = (count_reg != '0);
    assign pop     = q_take && q_valid;
    assign q_op    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

/* src/rv32x_div.sv */
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on rv32x_pkg.
module rv32x_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rv32x_pkg::XLEN-1:0] dividend,
    input  logic [rv32x_pkg::XLEN-1:0] divisor,
    output logic                       done,
    output logic [rv32x_pkg::XLEN-1:0] quotient,
    output logic [rv32x_pkg::XLEN-1:0] remainder
);
    import rv32x_pkg::*;

    localparam int CNT_W = $clog2(XLEN+1);

    logic [XLEN-1:0]  quo_reg;
    logic [XLEN-1:0]  rem_reg;
    logic [XLEN-1:0]  dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [XLEN:0]    trial;
    logic [XLEN:0]    shifted;

    assign shifted   = {rem_reg, quo_reg[XLEN-1]};
    assign trial     = shifted - {1'b0, dsr_reg};
    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (!trial[XLEN])
            begin
                rem_reg <= trial[XLEN-1:0];
                quo_reg <= {quo_reg[XLEN-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[XLEN-1:0];
                quo_reg <= {quo_reg[XLEN-2:0], 1'b0};
            end
        end
    end

    // hold done and the result until the next start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(XLEN);
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* src/rv32x_back.sv */
// Back end: register file, pc, ALU, multiplier stage and result register.
// Depends on rv32x_pkg and rv32x_div.
module rv32x_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  rv32x_pkg::op_t          q_op,
    output logic                    q_take,
    output logic                    valid,
    input  logic                    stall,
    output logic [31:0]             fetch_address,
    output logic                    data_access,
    output logic [31:0]             data_address,
    output logic                    write_enable,
    output logic [4:0]              write_index,
    output logic [31:0]             write_value,
    output logic [31:0]             next_pc,
    output logic                    branch_taken
);
    import rv32x_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [XLEN-1:0] rf_reg [REG_COUNT];
    logic [XLEN-1:0] pc_reg;
    logic [1:0]      state_reg;
    logic            out_valid_reg;
    logic [XLEN-1:0] mul_reg;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] opb;
    logic            out_free;
    logic            fire;
    logic            div_start;
    logic            div_done;
    logic [XLEN-1:0] div_q;
    logic [XLEN-1:0] div_r;
    logic [XLEN-1:0] val;
    logic            wr;
    logic            dacc;
    logic            taken;
    logic            finish;

    assign a   = (q_op.ra == '0) ? '0 : rf_reg[q_op.ra];
    assign b   = (q_op.rb == '0) ? '0 : rf_reg[q_op.rb];
    assign opb = q_op.use_imm ? q_op.imm : b;
    assign out_free = !out_valid_reg || !stall;

    rv32x_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a),
        .divisor   (b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign div_start = (state_reg == ST_IDLE) && q_valid && q_op.is_div;

    always_comb
    begin
        val   = '0;
        wr    = 1'b1;
        dacc  = 1'b0;
        taken = 1'b0;
        unique case (q_op.cmd)
            CMD_LI:             val = q_op.imm;
            CMD_LW, CMD_SW:
            begin
                dacc = 1'b1;
                wr   = 1'b0;
            end
            CMD_ADD, CMD_ADDI:  val = a + opb;
            CMD_AND, CMD_ANDI:  val = a & opb;
            CMD_OR, CMD_ORI:    val = a | opb;
            CMD_XOR, CMD_XORI:  val = a ^ opb;
            CMD_SLL, CMD_SLLI:  val = a << opb[4:0];
            CMD_SRL, CMD_SRLI:  val = a >> opb[4:0];
            CMD_SUB:            val = a - b;
            CMD_MUL:            val = mul_reg;
            CMD_DIV:            val = (b == '0) ? '1 : div_q;
            CMD_REM:            val = (b == '0) ? a : div_r;
            CMD_BEQ:
            begin
                wr    = 1'b0;
                taken = (a == b);
            end
            CMD_BNE:
            begin
                wr    = 1'b0;
                taken = (a != b);
            end
            default:            wr = 1'b0;
        endcase
        if (q_op.rd == '0)
        begin
            wr = 1'b0;
        end
    end

    // retire when the operand-dependent result is ready
    always_comb
    begin
        finish = 1'b0;
        unique case (state_reg)
            ST_IDLE: finish = q_valid && !q_op.is_div && (q_op.cmd != CMD_MUL);
            ST_MUL:  finish = 1'b1;
            ST_DIV:  finish = div_done;
            default: finish = 1'b0;
        endcase
    end

    assign fire   = finish && out_free;
    assign q_take = fire;
    assign valid  = out_valid_reg;

    always_ff @(posedge clk)
    begin
        mul_reg <= XLEN'(a * b);
        if (fire)
        begin
            fetch_address <= pc_reg;
            data_access   <= dacc;
            data_address  <= dacc ? a + q_op.imm : '0;
            write_enable  <= wr;
            write_index   <= wr ? q_op.rd : '0;
            write_value   <= wr ? val : '0;
            next_pc       <= taken ? pc_reg + q_op.imm : pc_reg + XLEN'(4);
            branch_taken  <= taken;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= ST_IDLE;
                pc_reg        <= taken ? pc_reg + q_op.imm : pc_reg + XLEN'(4);
                if (wr)
                begin
                    rf_reg[q_op.rd] <= val;
                end
            end
            else
            begin
                if (!stall)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (state_reg == ST_IDLE && q_valid)
                begin
                    if (q_op.is_div)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else if (q_op.cmd == CMD_MUL)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
            end
        end
    end

endmodule

/* src/rv32_subset_execute_step.sv */
// Top level of the rv32 subset execute step: front queue plus back executor.
// Depends on rv32x_pkg, rv32x_front and rv32x_back.
//
//   channel  | handshake           | words
//   in       | in_valid/in_stall   | command, dest_reg, src_reg_a, src_reg_b, immediate
//   out      | out_valid/out_stall | fetch_address .. branch_taken
//
// ALU and branch words retire one per cycle from the queue while the output is not
// stalled; mul waits for its product register; div and rem wait for the radix-2
// divider. A two-entry queue lets input words land while the back end works.
// Reset clears pc, the register file, the queue and the output valid at once.
// A stalled output holds its word; the back end waits until it is taken.
module rv32_subset_execute_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         command,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src_reg_a,
    input  logic [4:0]         src_reg_b,
    input  logic signed [31:0] immediate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        fetch_address,
    output logic               data_access,
    output logic [31:0]        data_address,
    output logic               write_enable,
    output logic [4:0]         write_index,
    output logic [31:0]        write_value,
    output logic [31:0]        next_pc,
    output logic               branch_taken
);
    import rv32x_pkg::*;

    logic q_valid;
    op_t  q_op;
    logic q_take;

    rv32x_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .stall     (in_stall),
        .command   (command),
        .dest_reg  (dest_reg),
        .src_reg_a (src_reg_a),
        .src_reg_b (src_reg_b),
        .immediate (immediate),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_take    (q_take)
    );

    rv32x_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_take        (q_take),
        .valid         (out_valid),
        .stall         (out_stall),
        .fetch_address (fetch_address),
        .data_access   (data_access),
        .data_address  (data_address),
        .write_enable  (write_enable),
        .write_index   (write_index),
        .write_value   (write_value),
        .next_pc       (next_pc),
        .branch_taken  (branch_taken)
    );

    a_take_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid)
        else $error("back end took from an empty queue");

    a_no_data_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !data_access) |-> (data_address == '0))
        else $error("data address without access");

    a_x0_never: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_enable) |-> (write_index != '0))
        else $error("write to x0 reported");

endmodule
